// ----- rtl/median_filter_window_macros.svh -----
// Assertion macros shared by the median filter RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef MEDIAN_FILTER_WINDOW_MACROS_SVH
`define MEDIAN_FILTER_WINDOW_MACROS_SVH
`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define MFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Whenever the condition holds, the consequence must hold in the next cycle.
`define MFW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MFW_ASSERT(lbl, prop, msg)
`define MFW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/mfw_pkg.sv -----
// Shared types and constants of the median filter window block.
// No dependencies; imported by the top level, the front end and the back end.
package mfw_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_RADIUS = 3;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CFG_DW = 16;
  localparam int CFG_IW = 2;

  localparam logic [10:0] RST_FRAME_WIDTH   = 11'd640;
  localparam logic [15:0] RST_FRAME_HEIGHT  = 16'd480;
  localparam logic [1:0]  RST_WINDOW_RADIUS = 2'd1;

  typedef enum logic [CFG_IW-1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_WINDOW_RADIUS = 2'd2
  } cfg_reg_e_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic       filler;
  } pix_beat_t;

  typedef struct packed {
    logic [7:0] median;
    logic       last_of_frame;
  } res_beat_t;

endpackage

// ----- rtl/median_filter_window.sv -----
// Top level of the streaming square-window median filter.
// Depends on mfw_pkg, mfw_front, mfw_queue and mfw_back.
//
//   Port group                      Dir  Beat contents
//   pix_valid / pix_ready / pix     in   pixel (8b), filler (1b)
//   res_valid / res_ready / res     out  median (8b), last_of_frame (1b)
//   cfg_we / cfg_index / cfg_data   in   frame_width, frame_height, window_radius
//
// One beat is taken per clock when the queue has room, giving one pixel per cycle.
// A result passes the front stage register (loaded at the edge that accepts its pixel),
// a queue slot, and the two rank stages and the output register of the back end.
// Reset is synchronous and clears all counters and valid flags; no clearing pass.
// A stalled result holds the back end; the four-entry queue then fills and
// pix_ready drops, counting the beat still in the front stage.
module median_filter_window #(
  parameter int MAX_WIDTH  = mfw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = mfw_pkg::DEF_MAX_RADIUS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pix_valid,
  output logic                        pix_ready,
  input  mfw_pkg::pix_beat_t          pix,
  output logic                        res_valid,
  input  logic                        res_ready,
  output mfw_pkg::res_beat_t          res,
  input  logic                        cfg_we,
  input  logic [mfw_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [mfw_pkg::CFG_DW-1:0]  cfg_data
);
  import mfw_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH+1);
  localparam int RW   = $clog2(MAX_RADIUS+1);
  localparam int NSEL = (2*MAX_RADIUS+1)*(2*MAX_RADIUS+1);
  localparam int QNW  = $clog2(QUEUE_DEPTH+1);

  logic [10:0]      frame_width;
  logic [15:0]      frame_height;
  logic [1:0]       window_radius;
  logic             restart;

  logic [CW-1:0]    eff_w;
  logic [15:0]      eff_h;
  logic [RW-1:0]    eff_r;

  logic             push, pop, q_valid;
  logic [NSEL*8:0]  push_data, q_data;
  logic [QNW-1:0]   q_count;

  // Any write to a known register restarts the frame at position zero.
  always_comb begin
    case (cfg_reg_e_t'(cfg_index))
      CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_WINDOW_RADIUS: restart = cfg_we;
      default: restart = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      window_radius <= RST_WINDOW_RADIUS;
    end else if (cfg_we) begin
      case (cfg_reg_e_t'(cfg_index))
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data[10:0];
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        CFG_WINDOW_RADIUS: window_radius <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped: zero width or height acts as one, and
  // width and radius saturate at the build limits.
  always_comb begin
    if (frame_width == 11'd0) begin
      eff_w = CW'(1);
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      eff_w = CW'(MAX_WIDTH);
    end else begin
      eff_w = CW'(frame_width);
    end
    eff_h = (frame_height == 16'd0) ? 16'd1 : frame_height;
    eff_r = (32'(window_radius) > 32'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : RW'(window_radius);
  end

  mfw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS),
    .CW         (CW),
    .RW         (RW),
    .NSEL       (NSEL),
    .QNW        (QNW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .eff_r     (eff_r),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .q_count   (q_count),
    .push      (push),
    .push_data (push_data)
  );

  mfw_queue #(
    .DW    (NSEL*8+1),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (q_valid),
    .head_data  (q_data),
    .count      (q_count)
  );

  mfw_back #(
    .NSEL (NSEL)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );
endmodule

// ----- rtl/mfw_queue.sv -----
// Small FIFO between the window front end and the median back end.
// Generic data width; depends only on the assertion macro header.
`include "median_filter_window_macros.svh"
module mfw_queue #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  logic [DW-1:0]                push_data,
  input  logic                         pop,
  output logic                         head_valid,
  output logic [DW-1:0]                head_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH+1);

  logic [DW-1:0] slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic          do_pop;

  assign do_pop     = pop && (count != '0);
  assign head_valid = (count != '0);
  assign head_data  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PW'(DEPTH-1)) ? '0 : wptr + PW'(1);
      end
      if (do_pop) begin
        rptr <= (rptr == PW'(DEPTH-1)) ? '0 : rptr + PW'(1);
      end
      count <= count + NW'(push) - NW'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

  `MFW_ASSERT(a_queue_no_overflow, !(push && !do_pop && count == NW'(DEPTH)), "queue overflow")
  `MFW_ASSERT(a_queue_pop_nonempty, !(pop && count == '0), "pop from empty queue")
endmodule

// ----- rtl/mfw_front.sv -----
// Front end: accepts pixel beats, tracks frame positions, runs the line stores
// and the window registers, and pads each window for the median back end.
// Depends on mfw_pkg and the assertion macro header.
`include "median_filter_window_macros.svh"
module mfw_front #(
  parameter int MAX_WIDTH  = mfw_pkg::DEF_MAX_WIDTH,
  parameter int MAX_RADIUS = mfw_pkg::DEF_MAX_RADIUS,
  parameter int CW         = $clog2(MAX_WIDTH+1),
  parameter int RW         = $clog2(MAX_RADIUS+1),
  parameter int NSEL       = (2*MAX_RADIUS+1)*(2*MAX_RADIUS+1),
  parameter int QNW        = $clog2(mfw_pkg::QUEUE_DEPTH+1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  restart,
  input  logic [CW-1:0]         eff_w,
  input  logic [15:0]           eff_h,
  input  logic [RW-1:0]         eff_r,
  input  logic                  pix_valid,
  output logic                  pix_ready,
  input  mfw_pkg::pix_beat_t    pix,
  input  logic [QNW-1:0]        q_count,
  output logic                  push,
  output logic [NSEL*8:0]       push_data
);
  import mfw_pkg::*;

  localparam int SIDE = 2*MAX_RADIUS + 1;
  localparam int HIST = 2*MAX_RADIUS;
  localparam int AW   = $clog2(MAX_WIDTH);
  localparam int TW   = CW + RW;

  // Position and lag counters.
  logic [AW-1:0] in_column;
  logic [16:0]   in_row;
  logic [AW-1:0] out_column;
  logic [15:0]   out_row;
  logic [TW-1:0] k_cnt;

  // Stage 1 registers.
  logic                s1_valid;
  logic                s1_res;
  logic                s1_last;
  logic [7:0]          s1_value;
  logic [AW-1:0]       s1_addr;
  logic [SIDE-1:0]     s1_radc, s1_radr, s1_okc, s1_okr;
  logic                fwd;
  logic [HIST*8-1:0]   fwd_data;
  logic [HIST*8-1:0]   rd;

  logic [HIST*8-1:0]   lines [MAX_WIDTH];
  logic [SIDE*8-1:0]   win [SIDE];
  logic [SIDE*8-1:0]   win_new [SIDE];

  logic                acc, in_frame, take, is_res, last;
  logic [TW-1:0]       thr;
  logic [CW-1:0]       col_inc;
  logic                col_wrap;
  logic [SIDE-1:0]     radc, radr, okc, okr;
  logic [HIST*8-1:0]   old_entry;
  logic [SIDE*8-1:0]   col;
  logic [HIST*8-1:0]   wentry;

  assign pix_ready = (int'(q_count) + int'(s1_valid && s1_res)) < QUEUE_DEPTH;
  assign acc       = pix_valid && pix_ready;
  assign in_frame  = in_row < {1'b0, eff_h};
  assign take      = acc && !(pix.filler && in_frame);
  assign thr       = TW'(eff_r) * TW'(eff_w) + TW'(eff_r);
  assign is_res    = k_cnt >= thr;
  assign last      = (CW'(out_column) == eff_w - CW'(1)) && (out_row >= eff_h - 16'd1);
  assign col_inc   = CW'(in_column) + CW'(1);
  assign col_wrap  = col_inc >= eff_w;

  // Neighborhood masks for the result position: inside the radius and inside the frame.
  always_comb begin
    int dx;
    int nx;
    int ny;
    for (int c = 0; c < SIDE; c++) begin
      dx      = c - (SIDE-1) + int'(eff_r);
      nx      = int'(out_column) + dx;
      ny      = int'(out_row) + dx;
      radc[c] = c >= (SIDE-1) - 2*int'(eff_r);
      radr[c] = radc[c];
      okc[c]  = (nx >= 0) && (nx < int'(eff_w));
      okr[c]  = (ny >= 0) && (ny < int'(eff_h));
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
      k_cnt      <= '0;
      s1_valid   <= 1'b0;
    end else begin
      s1_valid <= take;
      if (take) begin
        if (is_res && last) begin
          // The final result of the frame: every position starts over.
          in_column  <= '0;
          in_row     <= '0;
          out_column <= '0;
          out_row    <= '0;
          k_cnt      <= '0;
        end else begin
          if (col_wrap) begin
            in_column <= '0;
            in_row    <= in_row + 17'd1;
          end else begin
            in_column <= col_inc[AW-1:0];
          end
          if (!is_res) begin
            k_cnt <= k_cnt + TW'(1);
          end else if (CW'(out_column) + CW'(1) >= eff_w) begin
            out_column <= '0;
            out_row    <= out_row + 16'd1;
          end else begin
            out_column <= out_column + AW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_value <= (!pix.filler && in_frame) ? pix.pixel : 8'd0;
      s1_addr  <= in_column;
      s1_res   <= is_res;
      s1_last  <= last;
      s1_radc  <= radc;
      s1_radr  <= radr;
      s1_okc   <= okc;
      s1_okr   <= okr;
      // Same column written by the beat now in stage 1: the read returns stale data.
      fwd      <= s1_valid && (s1_addr == in_column);
      fwd_data <= wentry;
      rd       <= lines[in_column];
    end
    if (s1_valid) begin
      lines[s1_addr] <= wentry;
      for (int c = 0; c < SIDE; c++) begin
        win[c] <= win_new[c];
      end
    end
  end

  // Vertical shift through the line stores, then the new column enters the window.
  assign old_entry = fwd ? fwd_data : rd;
  assign col       = {s1_value, old_entry};
  assign wentry    = col[SIDE*8-1:8];

  always_comb begin
    for (int c = 0; c < SIDE-1; c++) begin
      win_new[c] = win[c+1];
    end
    win_new[SIDE-1] = col;
  end

  // Places outside the radius are split evenly between 0 and 255 by checkerboard,
  // which leaves the middle element of the full set equal to the window median.
  always_comb begin
    logic [7:0] v;
    for (int c = 0; c < SIDE; c++) begin
      for (int j = 0; j < SIDE; j++) begin
        if (s1_radc[c] && s1_radr[j]) begin
          v = (s1_okc[c] && s1_okr[j]) ? win_new[c][j*8 +: 8] : 8'd0;
        end else begin
          v = (((c + j) & 1) != 0) ? 8'hFF : 8'h00;
        end
        push_data[(c*SIDE + j)*8 +: 8] = v;
      end
    end
    push_data[NSEL*8] = s1_last;
  end

  assign push = s1_valid && s1_res;

  `MFW_ASSERT_NEXT(a_front_fwd, take && s1_valid && (s1_addr == in_column), fwd,
                   "line store forwarding missed")
endmodule

// ----- rtl/mfw_back.sv -----
// Back end: ranks the padded window and picks the middle value, three stages.
// Depends on mfw_pkg and the assertion macro header.
`include "median_filter_window_macros.svh"
module mfw_back #(
  parameter int NSEL = 49
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  logic [NSEL*8:0]      q_data,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output mfw_pkg::res_beat_t   res
);
  import mfw_pkg::*;

  localparam int KW = $clog2(NSEL);

  logic                 adv;
  logic [NSEL-1:0]      lt_d [NSEL];

  logic                 a_v, a_last;
  logic [NSEL*8-1:0]    a_vals;
  logic [NSEL-1:0]      a_lt [NSEL];

  logic                 b_v, b_last;
  logic [NSEL*8-1:0]    b_vals;
  logic [KW-1:0]        b_rank [NSEL];

  logic [NSEL-1:0]      match;
  logic [7:0]           med;

  // Output held while the consumer stalls; everything behind it waits.
  assign adv = !res_valid || res_ready;
  assign pop = q_valid && adv;

  // Rank with ties broken by position, so the ranks are a permutation.
  always_comb begin
    for (int i = 0; i < NSEL; i++) begin
      for (int j = 0; j < NSEL; j++) begin
        lt_d[i][j] = (q_data[j*8 +: 8] < q_data[i*8 +: 8]) ||
                     ((q_data[j*8 +: 8] == q_data[i*8 +: 8]) && (j < i));
      end
    end
  end

  always_comb begin
    med = 8'd0;
    for (int i = 0; i < NSEL; i++) begin
      match[i] = (b_rank[i] == KW'(NSEL/2));
      med      = med | (match[i] ? b_vals[i*8 +: 8] : 8'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      a_v       <= q_valid;
      b_v       <= a_v;
      res_valid <= b_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_vals <= q_data[NSEL*8-1:0];
      a_last <= q_data[NSEL*8];
      for (int i = 0; i < NSEL; i++) begin
        a_lt[i]   <= lt_d[i];
        b_rank[i] <= KW'($countones(a_lt[i]));
      end
      b_vals <= a_vals;
      b_last <= a_last;
      res.median        <= med;
      res.last_of_frame <= b_last;
    end
  end

  `MFW_ASSERT(a_back_one_median, !b_v || $onehot(match), "median rank not unique")
endmodule
